>>> rtl/realized_volatility_tracker_macros.svh
// assertion macros for the realized volatility tracker
// used by rtl modules that carry concurrent checks; no other dependencies
`ifndef REALIZED_VOLATILITY_TRACKER_MACROS_SVH
`define REALIZED_VOLATILITY_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
`define RVT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rvt check failed");
`define RVT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rvt check failed");
`else
`define RVT_ASSERT_IMP(label, clk, rst, ante, cons)
`define RVT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/rvt_pkg.sv
// shared types, codes and constants for the realized volatility tracker
// no dependencies
package rvt_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int LOG_W     = 25;

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_INTR   = 2'd1;
  localparam logic [1:0] KIND_RESUME = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DECAY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 2'd2;

  localparam logic [15:0] DECAY_RESET  = 16'd62259;
  localparam logic [8:0]  WINDOW_RESET = 9'd15;
  localparam logic [31:0] SEED_RESET   = 32'd0;

  localparam logic [8:0]  WINDOW_LIMIT   = 9'd300;
  localparam logic [16:0] MINUTES_FACTOR = 17'd90720;
  localparam logic [29:0] LN2_Q30        = 30'd744261118;
  localparam logic [15:0] VOL_SCALE      = 16'd40000;

  typedef enum logic [4:0] {
    DP_NOP, DP_CAPTURE, DP_INTR, DP_RESUME, DP_FIRST, DP_LATCH,
    DP_LOAD_LOG, DP_NORM, DP_LOG_ITER, DP_SAVE_LOG, DP_MAG_MUL, DP_SQ_MUL,
    DP_ACC, DP_DIV_ITER, DP_P_LO, DP_P_HI, DP_P_SUM, DP_Q_LO, DP_Q_HI,
    DP_Q_SUM, DP_SQRT_ITER, DP_WVOL, DP_F_SUB_MUL, DP_F_SUB, DP_F_DEC_MUL,
    DP_F_DEC, DP_F_ADD_MUL, DP_F_FIN, DP_N_MUL, DP_N_FIN, DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [4:0] cnt;
    logic       sel;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       ready;
    logic       intr;
    logic       full;
    logic       out_busy;
  } dp_status_t;

endpackage

>>> rtl/rvt_in_if.sv
// input channel of the tracker: one event per transfer
// depends on nothing
interface rvt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] price;
  logic        source_ready;

  modport source (output valid, kind, price, source_ready, input ready);
  modport sink (input valid, kind, price, source_ready, output ready);
endinterface

>>> rtl/rvt_out_if.sv
// result channel of the tracker: running volatility per transfer
// depends on nothing
interface rvt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] volatility;

  modport source (output valid, volatility, input ready);
  modport sink (input valid, volatility, output ready);
endinterface

>>> rtl/rvt_datapath.sv
// datapath: configuration, tracker state, shared multiplier, divider, square root
// depends on rvt_pkg and the assertion macro header
`include "realized_volatility_tracker_macros.svh"
module rvt_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  rvt_pkg::dp_cmd_t             cmd,
  output rvt_pkg::dp_status_t          status,
  input  logic                         cfg_we,
  input  logic [rvt_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [31:0]                  cfg_wdata,
  input  logic [1:0]                   in_kind,
  input  logic [31:0]                  in_price,
  input  logic                         in_src,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic [31:0]                  res_vol
);
  import rvt_pkg::*;

  logic [15:0] decay;
  logic [8:0]  window;
  logic        ready_flag, intr_flag;
  logic [1:0]  kind_q;
  logic [31:0] price_q;
  logic        src_q;
  logic [31:0] latest, recorded;
  logic [47:0] sum;
  logic [8:0]  tick;
  logic [31:0] wvol, run, prior;
  logic [31:0] m;
  logic [4:0]  e;
  logic [LOG_W-1:0] r, la;
  logic        zero_q;
  logic [65:0] prod;
  logic [16:0] dv;
  logic [8:0]  rem;
  logic [64:0] acc, v;
  logic [63:0] res, bitv;
  logic        sat;

  logic [16:0] w;
  logic [8:0]  win_lim, eff, divisor;
  logic [4:0]  sh, e_new;
  logic [31:0] m_sh;
  logic        hi_zero;
  logic [LOG_W-1:0] lb, dlog;
  logic [32:0] mul_a, mul_b;
  logic [65:0] prod_c;
  logic [32:0] lt;
  logic [48:0] sum_c;
  logic [9:0]  rt;
  logic        ge;
  logic [64:0] vsum;
  logic [63:0] st;
  logic [31:0] vdiff, pt;
  logic [32:0] radd;

  assign w       = 17'h10000 - {1'b0, decay};
  assign win_lim = (window > WINDOW_LIMIT) ? WINDOW_LIMIT : window;
  assign eff     = (win_lim == 9'd0) ? 9'd1 : win_lim;
  assign divisor = (tick == 9'd0) ? 9'd1 : tick;

  assign sh      = 5'(5'd16 >> cmd.cnt);
  assign hi_zero = (m >> (6'd32 - {1'b0, sh})) == 32'd0;
  assign m_sh    = m << sh;
  assign e_new   = hi_zero ? e - sh : e;

  assign lb    = zero_q ? '0 : r;
  assign dlog  = (la >= lb) ? la - lb : lb - la;
  assign vdiff = (wvol >= prior) ? wvol - prior : prior - wvol;
  assign pt    = prod[47:16];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      DP_LOG_ITER: begin
        mul_a = {1'b0, m};
        mul_b = {1'b0, m};
      end
      DP_MAG_MUL: begin
        mul_a = 33'(dlog);
        mul_b = 33'(LN2_Q30);
      end
      DP_SQ_MUL: begin
        mul_a = 33'(prod[54:35]);
        mul_b = 33'(prod[54:35]);
      end
      DP_P_LO: begin
        mul_a = 33'(dv);
        mul_b = 33'(sum[23:0]);
      end
      DP_P_HI: begin
        mul_a = 33'(dv);
        mul_b = 33'(sum[47:24]);
      end
      DP_Q_LO: begin
        mul_a = 33'(acc[24:0]);
        mul_b = 33'(VOL_SCALE);
      end
      DP_Q_HI: begin
        mul_a = 33'(acc[48:25]);
        mul_b = 33'(VOL_SCALE);
      end
      DP_F_SUB_MUL: begin
        mul_a = {1'b0, prior};
        mul_b = 33'(w);
      end
      DP_F_DEC_MUL: begin
        mul_a = {1'b0, acc[31:0]};
        mul_b = 33'(decay);
      end
      DP_F_ADD_MUL: begin
        mul_a = {1'b0, wvol};
        mul_b = 33'(w);
      end
      DP_N_MUL: begin
        mul_a = {1'b0, vdiff};
        mul_b = 33'(w);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_c = mul_a * mul_b;
  assign lt     = prod_c[63:31];
  assign sum_c  = {1'b0, sum} + {9'd0, prod[39:0]};
  assign rt     = {rem, dv[16]};
  assign ge     = rt >= {1'b0, divisor};
  assign vsum   = v + (65'(prod[39:0]) << 25);
  assign st     = res + bitv;
  assign radd   = {1'b0, acc[31:0]} + {1'b0, pt};

  always_ff @(posedge clk) begin
    if (rst) begin
      decay      <= DECAY_RESET;
      window     <= WINDOW_RESET;
      ready_flag <= 1'b0;
      intr_flag  <= 1'b0;
      latest     <= '0;
      recorded   <= '0;
      sum        <= '0;
      tick       <= '0;
      wvol       <= '0;
      prior      <= '0;
      run        <= SEED_RESET;
      res_valid  <= 1'b0;
    end else begin
      if (cmd.op == DP_EMIT) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      case (cmd.op)
        DP_CAPTURE: begin
          kind_q  <= in_kind;
          price_q <= in_price;
          src_q   <= in_src;
        end
        DP_INTR: intr_flag <= 1'b1;
        DP_RESUME: begin
          recorded  <= latest;
          sum       <= '0;
          tick      <= '0;
          wvol      <= '0;
          intr_flag <= 1'b0;
        end
        DP_FIRST: begin
          latest <= price_q;
          if (src_q) begin
            ready_flag <= 1'b1;
            recorded   <= price_q;
            sum        <= '0;
            tick       <= '0;
            wvol       <= '0;
          end
        end
        DP_LATCH: latest <= price_q;
        DP_LOAD_LOG: begin
          m      <= cmd.sel ? recorded : latest;
          zero_q <= cmd.sel ? (recorded == 32'd0) : (latest == 32'd0);
          e      <= 5'd31;
        end
        DP_NORM: begin
          if (hi_zero) begin
            m <= m_sh;
          end
          e <= e_new;
          r <= {e_new, 20'd0};
        end
        DP_LOG_ITER: begin
          if (lt[32]) begin
            m <= lt[32:1];
            r <= r | (LOG_W'(1) << (5'd19 - cmd.cnt));
          end else begin
            m <= lt[31:0];
          end
        end
        DP_SAVE_LOG: la <= zero_q ? '0 : r;
        DP_MAG_MUL: prod <= prod_c;
        DP_SQ_MUL: prod <= prod_c;
        DP_ACC: begin
          sum      <= sum_c[48] ? '1 : sum_c[47:0];
          tick     <= tick + 9'd1;
          recorded <= latest;
          dv       <= MINUTES_FACTOR;
          rem      <= '0;
        end
        DP_DIV_ITER: begin
          rem <= ge ? 9'(rt - {1'b0, divisor}) : rt[8:0];
          dv  <= {dv[15:0], ge};
        end
        DP_P_LO: prod <= prod_c;
        DP_P_HI: begin
          acc  <= prod[64:0];
          prod <= prod_c;
        end
        DP_P_SUM: acc <= acc + (65'(prod[40:0]) << 24);
        DP_Q_LO: begin
          sat  <= |acc[64:49];
          prod <= prod_c;
        end
        DP_Q_HI: begin
          v    <= prod[64:0];
          prod <= prod_c;
        end
        DP_Q_SUM: begin
          v    <= vsum;
          sat  <= sat | vsum[64];
          res  <= '0;
          bitv <= 64'd1 << 62;
        end
        DP_SQRT_ITER: begin
          if (v[63:0] >= st) begin
            v   <= {1'b0, v[63:0] - st};
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          bitv <= bitv >> 2;
        end
        DP_WVOL: wvol <= sat ? '1 : res[31:0];
        DP_F_SUB_MUL: prod <= prod_c;
        DP_F_SUB: acc <= (run > pt) ? 65'(run - pt) : '0;
        DP_F_DEC_MUL: prod <= prod_c;
        DP_F_DEC: acc <= 65'(pt);
        DP_F_ADD_MUL: prod <= prod_c;
        DP_F_FIN: begin
          run  <= radd[32] ? '1 : radd[31:0];
          sum  <= '0;
          tick <= '0;
        end
        DP_N_MUL: prod <= prod_c;
        DP_N_FIN: begin
          if (wvol >= prior) begin
            run <= ({1'b0, run} + {1'b0, pt} > 33'hFFFFFFFF) ? '1 : run + pt;
          end else begin
            run <= (run > pt) ? run - pt : '0;
          end
          prior <= wvol;
        end
        DP_EMIT: res_vol <= run;
        default: ;
      endcase
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_DECAY:  decay  <= cfg_wdata[15:0];
          CFG_WINDOW: window <= cfg_wdata[8:0];
          CFG_SEED: begin
            if (!ready_flag) begin
              run <= cfg_wdata;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    status.kind     = kind_q;
    status.ready    = ready_flag;
    status.intr     = intr_flag;
    status.full     = tick >= eff;
    status.out_busy = res_valid && !res_ready;
  end

  `RVT_ASSERT_IMP(a_tick_range, clk, rst, 1'b1, tick <= WINDOW_LIMIT)
  `RVT_ASSERT_IMP(a_div_rem, clk, rst, cmd.op == DP_DIV_ITER, rem < divisor)
  `RVT_ASSERT_IMP(a_emit_free, clk, rst, cmd.op == DP_EMIT, !(res_valid && !res_ready))
  `RVT_ASSERT_NXT(a_emit_valid, clk, rst, cmd.op == DP_EMIT, res_valid)

endmodule

>>> rtl/rvt_ctrl.sv
// controller: sequences each event through the datapath steps
// depends on rvt_pkg
module rvt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rvt_pkg::dp_status_t status,
  output rvt_pkg::dp_cmd_t    cmd
);
  import rvt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_LOAD, S_NORM, S_LOG, S_SAVE, S_MAG, S_SQ, S_ACC,
    S_DIV, S_P_LO, S_P_HI, S_P_SUM, S_Q_LO, S_Q_HI, S_Q_SUM, S_SQRT, S_WVOL,
    S_F_SUB_MUL, S_F_SUB, S_F_DEC_MUL, S_F_DEC, S_F_ADD_MUL, S_F_FIN,
    S_N_MUL, S_N_FIN, S_EMIT
  } state_t;

  state_t     state, state_next;
  logic [4:0] cnt, cnt_next;
  logic       sel, sel_next;
  dp_op_t     op;

  assign in_ready = (state == S_IDLE);
  assign cmd.op   = op;
  assign cmd.cnt  = cnt;
  assign cmd.sel  = sel;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    sel_next   = sel;
    op         = DP_NOP;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op         = DP_CAPTURE;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        case (status.kind)
          KIND_INTR:   op = DP_INTR;
          KIND_RESUME: op = DP_RESUME;
          KIND_TICK: begin
            state_next = S_EMIT;
            if (!status.ready) begin
              op = DP_FIRST;
            end else begin
              op = DP_LATCH;
              if (!status.intr) begin
                state_next = S_LOAD;
                sel_next   = 1'b0;
              end
            end
          end
          default: op = DP_NOP;
        endcase
      end
      S_LOAD: begin
        op         = DP_LOAD_LOG;
        cnt_next   = '0;
        state_next = S_NORM;
      end
      S_NORM: begin
        op       = DP_NORM;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd4) begin
          cnt_next   = '0;
          state_next = S_LOG;
        end
      end
      S_LOG: begin
        op       = DP_LOG_ITER;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd19) begin
          state_next = sel ? S_MAG : S_SAVE;
        end
      end
      S_SAVE: begin
        op         = DP_SAVE_LOG;
        sel_next   = 1'b1;
        state_next = S_LOAD;
      end
      S_MAG: begin
        op         = DP_MAG_MUL;
        state_next = S_SQ;
      end
      S_SQ: begin
        op         = DP_SQ_MUL;
        state_next = S_ACC;
      end
      S_ACC: begin
        op         = DP_ACC;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        op       = DP_DIV_ITER;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd16) begin
          state_next = S_P_LO;
        end
      end
      S_P_LO: begin
        op         = DP_P_LO;
        state_next = S_P_HI;
      end
      S_P_HI: begin
        op         = DP_P_HI;
        state_next = S_P_SUM;
      end
      S_P_SUM: begin
        op         = DP_P_SUM;
        state_next = S_Q_LO;
      end
      S_Q_LO: begin
        op         = DP_Q_LO;
        state_next = S_Q_HI;
      end
      S_Q_HI: begin
        op         = DP_Q_HI;
        state_next = S_Q_SUM;
      end
      S_Q_SUM: begin
        op         = DP_Q_SUM;
        cnt_next   = '0;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        op       = DP_SQRT_ITER;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd31) begin
          state_next = S_WVOL;
        end
      end
      S_WVOL: begin
        op         = DP_WVOL;
        state_next = status.full ? S_F_SUB_MUL : S_N_MUL;
      end
      S_F_SUB_MUL: begin
        op         = DP_F_SUB_MUL;
        state_next = S_F_SUB;
      end
      S_F_SUB: begin
        op         = DP_F_SUB;
        state_next = S_F_DEC_MUL;
      end
      S_F_DEC_MUL: begin
        op         = DP_F_DEC_MUL;
        state_next = S_F_DEC;
      end
      S_F_DEC: begin
        op         = DP_F_DEC;
        state_next = S_F_ADD_MUL;
      end
      S_F_ADD_MUL: begin
        op         = DP_F_ADD_MUL;
        state_next = S_F_FIN;
      end
      S_F_FIN: begin
        op         = DP_F_FIN;
        state_next = S_EMIT;
      end
      S_N_MUL: begin
        op         = DP_N_MUL;
        state_next = S_N_FIN;
      end
      S_N_FIN: begin
        op         = DP_N_FIN;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!status.out_busy) begin
          op         = DP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      sel   <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      sel   <= sel_next;
    end
  end

endmodule

>>> rtl/realized_volatility_tracker.sv
// Realized volatility tracker, top level.
// Channel samples carries one event per transfer: kind (tick, data interrupted,
// data resumed), a Q16.16 price and the source ready flag. Channel results
// carries the running volatility, percent in Q16.16, one transfer per tick.
// Interruption and resumption events give no result.
// The cfg port writes decay weight, window length and seed volatility; a seed
// written before the first ready tick also loads the running volatility.
// A tick through the full update runs two log2 passes on the shared
// multiplier, the divider and the square root before it loads the result
// register; when the window fills, extra blend steps come first.
// Other events occupy the block only to decode; ticks before ready or while
// interrupted go from decode straight to loading the result register.
// The next event is taken the cycle after the result is loaded.
// One output register holds the result; if the receiver stalls, a following
// tick waits at its last step until the register frees.
// Synchronous reset clears the control state, flags, window sums and result
module realized_volatility_tracker (
  input  logic                         clk,
  input  logic                         rst,
  rvt_in_if.sink                       samples,
  rvt_out_if.source                    results,
  input  logic                         cfg_we,
  input  logic [rvt_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [31:0]                  cfg_wdata
);
  import rvt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  rvt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .status   (status),
    .cmd      (cmd)
  );

  rvt_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_kind   (samples.kind),
    .in_price  (samples.price),
    .in_src    (samples.source_ready),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .res_vol   (results.volatility)
  );

endmodule

>>> verif/tb_realized_volatility_tracker.sv
// testbench for realized_volatility_tracker: directed table then random event streams
// depends on rvt_pkg, rvt_in_if, rvt_out_if and the tracker rtl
`timescale 1ns / 100ps

module tb_realized_volatility_tracker;
  import rvt_pkg::*;

  localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SUM_MAX = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [1:0]  KIND_NONE = 2'd3;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] price;
    logic        src_rdy;
    bit          typed;
    logic [31:0] vol;
  } event_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [31:0] cfg_wdata;

  rvt_in_if  in_ch ();
  rvt_out_if out_ch ();

  realized_volatility_tracker dut (
    .clk       (clk),
    .rst       (rst),
    .samples   (in_ch),
    .results   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [15:0] m_decay;
  logic [8:0]  m_window;
  logic [31:0] m_seed;
  bit          m_ready;
  bit          m_intr;
  logic [31:0] m_latest;
  logic [31:0] m_recorded;
  logic [63:0] m_sum;
  logic [8:0]  m_count;
  logic [31:0] m_wvol;
  logic [31:0] m_running;
  logic [31:0] m_prior;

  logic [31:0] vol_expected [$];
  int          errors;
  int          n_events;
  int          n_vols;
  int          n_windows;
  bit          idling;
  bit          row_typed;
  logic [31:0] row_vol;

  function automatic logic [63:0] log2_fix(logic [31:0] x);
    int          e;
    logic [127:0] m;
    logic [63:0] r;
    if (x == 0) return 64'd0;
    e = 31;
    while (!x[e]) e--;
    m = 128'(x) << (31 - e);
    r = 64'(e) << 20;
    for (int i = 19; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= (128'd1 << 32)) begin
        m = m >> 1;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] sat32(logic [127:0] v);
    return (v > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] window_vol_of(logic [8:0] cnt, logic [63:0] s);
    logic [127:0] f;
    logic [127:0] p;
    f = 128'(MINUTES_FACTOR) / 128'((cnt != 0) ? cnt : 9'd1);
    p = f * 128'(s);
    if (p > 128'(U64_MAX)) return 32'hFFFF_FFFF;
    if (p > 128'(U64_MAX / 64'(VOL_SCALE))) return 32'hFFFF_FFFF;
    return sat32(128'(root_floor(p[63:0] * 64'(VOL_SCALE))));
  endfunction

  task automatic restart_window();
    m_recorded = m_latest;
    m_sum = 0;
    m_count = 0;
    m_wvol = 0;
  endtask

  task automatic update_vol();
    logic [63:0] lp, lq, d, mag, w, h, t;
    logic [8:0]  eff;
    lp = log2_fix(m_latest);
    lq = log2_fix(m_recorded);
    d = (lp >= lq) ? lp - lq : lq - lp;
    mag = (d * 64'(LN2_Q30)) >> 35;
    w = 64'd65536 - 64'(m_decay);
    eff = (m_window < WINDOW_LIMIT) ? m_window : WINDOW_LIMIT;
    if (eff == 0) eff = 1;
    m_sum = m_sum + mag * mag;
    if (m_sum > SUM_MAX) m_sum = SUM_MAX;
    m_count = m_count + 9'd1;
    m_wvol = window_vol_of(m_count, m_sum);
    m_recorded = m_latest;
    if (m_count >= eff) begin
      h = 64'(m_running);
      t = (64'(m_prior) * w) >> 16;
      h = (h > t) ? h - t : 0;
      h = (h * 64'(m_decay)) >> 16;
      h = h + ((64'(m_wvol) * w) >> 16);
      m_running = sat32(128'(h));
      m_sum = 0;
      m_count = 0;
      n_windows++;
    end else begin
      h = 64'(m_running);
      if (m_wvol >= m_prior) begin
        h = h + ((64'(m_wvol - m_prior) * w) >> 16);
      end else begin
        t = (64'(m_prior - m_wvol) * w) >> 16;
        h = (h > t) ? h - t : 0;
      end
      m_running = sat32(128'(h));
      m_prior = m_wvol;
    end
  endtask

  task automatic apply_event(logic [1:0] kind, logic [31:0] price, logic src_rdy,
                             output bit emits, output logic [31:0] vol);
    emits = 0;
    vol = 0;
    case (kind)
      KIND_INTR: begin
        m_intr = 1;
      end
      KIND_RESUME: begin
        restart_window();
        m_intr = 0;
      end
      KIND_TICK: begin
        m_latest = price;
        if (!m_ready) begin
          if (src_rdy) begin
            m_ready = 1;
            restart_window();
          end
        end else if (!m_intr) begin
          update_vol();
        end
        emits = 1;
        vol = m_running;
      end
      default: ;
    endcase
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // predictor and checker, both sampled at the rising edge
  always @(posedge clk) begin
    bit          emits;
    logic [31:0] vol;
    logic [31:0] want;
    if (rst) begin
      m_decay = DECAY_RESET;
      m_window = WINDOW_RESET;
      m_seed = SEED_RESET;
      m_ready = 0;
      m_intr = 0;
      m_latest = 0;
      m_recorded = 0;
      m_sum = 0;
      m_count = 0;
      m_wvol = 0;
      m_prior = 0;
      m_running = SEED_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_DECAY:  m_decay = cfg_wdata[15:0];
          CFG_WINDOW: m_window = cfg_wdata[8:0];
          CFG_SEED: begin
            m_seed = cfg_wdata;
            if (!m_ready) m_running = m_seed;
          end
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        apply_event(in_ch.kind, in_ch.price, in_ch.source_ready, emits, vol);
        n_events++;
        if (emits) vol_expected.insert(vol_expected.size(), row_typed ? row_vol : vol);
      end
      if (out_ch.valid && out_ch.ready) begin
        n_vols++;
        if (vol_expected.size() == 0) begin
          errors++;
          $display("%0t: unexpected volatility transfer, actual %h", $realtime,
                   out_ch.volatility);
        end else begin
          want = vol_expected.pop_front();
          if (out_ch.volatility !== want) begin
            errors++;
            $display("%0t: volatility mismatch, expected %h, actual %h", $realtime,
                     want, out_ch.volatility);
          end
        end
      end
    end
  end

  // receiver with random stall bursts
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (idling && $urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_event(logic [1:0] kind, logic [31:0] price, logic src_rdy,
                            bit typed, logic [31:0] vol);
    if (idling && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.price <= price;
    in_ch.source_ready <= src_rdy;
    row_typed <= typed;
    row_vol <= vol;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    row_typed <= 1'b0;
    @(posedge clk);
    while (vol_expected.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] decay, logic [8:0] window, logic [31:0] seed);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_DECAY;
    cfg_wdata <= {16'd0, decay};
    @(posedge clk);
    cfg_idx <= CFG_WINDOW;
    cfg_wdata <= {23'd0, window};
    @(posedge clk);
    cfg_idx <= CFG_SEED;
    cfg_wdata <= seed;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] next_price(logic [31:0] prev);
    logic [63:0] step;
    case ($urandom_range(0, 39))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'd1;
      3, 4: return $urandom;
      default: begin
        step = (64'(prev) >> $urandom_range(4, 12)) + 64'($urandom_range(0, 3));
        if ($urandom_range(0, 1)) return (64'(prev) + step > 64'hFFFF_FFFF) ?
                                          32'hFFFF_FFFF : prev + step[31:0];
        return (64'(prev) > step) ? prev - step[31:0] : 32'd1;
      end
    endcase
  endfunction

  task automatic random_phase(int count);
    logic [31:0] price;
    int          r;
    price = 32'h0064_8000 + ($urandom & 32'h00FF_FFFF);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      price = next_price(price);
      if (r < 5)       send_event(KIND_INTR, $urandom, 1'($urandom), 0, 0);
      else if (r < 10) send_event(KIND_RESUME, $urandom, 1'($urandom), 0, 0);
      else if (r < 12) send_event(KIND_NONE, $urandom, 1'($urandom), 0, 0);
      else             send_event(KIND_TICK, price, $urandom_range(0, 7) == 0, 0, 0);
    end
  endtask

  event_row_t rows [$];

  initial begin
    errors = 0;
    n_events = 0;
    n_vols = 0;
    n_windows = 0;
    idling = 1;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_DECAY;
    cfg_wdata <= 32'd0;
    in_ch.valid <= 1'b0;
    in_ch.kind <= KIND_TICK;
    in_ch.price <= 32'd0;
    in_ch.source_ready <= 1'b0;
    row_typed <= 1'b0;
    row_vol <= 32'd0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // before ready: reset seed then a written seed
    rows = '{
      '{KIND_TICK, 32'hFFFF_FFFF, 1'b0, 1, 32'd0},
      '{KIND_INTR, 32'd5, 1'b1, 0, 32'd0},
      '{KIND_RESUME, 32'd5, 1'b1, 0, 32'd0},
      '{KIND_NONE, 32'hFFFF_FFFF, 1'b1, 0, 32'd0},
      '{KIND_TICK, 32'd0, 1'b0, 1, 32'd0}
    };
    foreach (rows[i]) send_event(rows[i].kind, rows[i].price, rows[i].src_rdy,
                                 rows[i].typed, rows[i].vol);
    set_regs(DECAY_RESET, WINDOW_RESET, 32'h0012_3456);
    rows = '{
      '{KIND_TICK, 32'h0001_0000, 1'b0, 1, 32'h0012_3456},
      '{KIND_TICK, 32'h0001_0000, 1'b1, 1, 32'h0012_3456},
      '{KIND_TICK, 32'hFFFF_FFFF, 1'b0, 0, 32'd0},
      '{KIND_TICK, 32'd1, 1'b0, 0, 32'd0},
      '{KIND_TICK, 32'd0, 1'b1, 0, 32'd0},
      '{KIND_TICK, 32'hFFFF_FFFF, 1'b0, 0, 32'd0},
      '{KIND_INTR, 32'd0, 1'b0, 0, 32'd0},
      '{KIND_TICK, 32'h0002_0000, 1'b0, 0, 32'd0},
      '{KIND_RESUME, 32'd0, 1'b0, 0, 32'd0},
      '{KIND_TICK, 32'h0003_0000, 1'b0, 0, 32'd0},
      '{KIND_NONE, 32'd7, 1'b0, 0, 32'd0},
      '{KIND_TICK, 32'h0002_8000, 1'b0, 0, 32'd0},
      '{KIND_TICK, 32'h0002_8001, 1'b0, 0, 32'd0},
      '{KIND_TICK, 32'h0002_7FFF, 1'b0, 0, 32'd0}
    };
    foreach (rows[i]) send_event(rows[i].kind, rows[i].price, rows[i].src_rdy,
                                 rows[i].typed, rows[i].vol);
    // seed after ready leaves the running volatility alone; window lowered mid-window
    set_regs(16'd0, 9'd2, 32'hFFFF_FFFF);
    rows = '{
      '{KIND_TICK, 32'h0005_0000, 1'b0, 0, 32'd0},
      '{KIND_TICK, 32'h0004_0000, 1'b0, 0, 32'd0}
    };
    foreach (rows[i]) send_event(rows[i].kind, rows[i].price, rows[i].src_rdy,
                                 rows[i].typed, rows[i].vol);
    set_regs(16'hFFFF, 9'd0, 32'd0);
    send_event(KIND_TICK, 32'h0008_0000, 1'b0, 0, 0);
    send_event(KIND_TICK, 32'h0001_0000, 1'b0, 0, 0);

    set_regs(16'hFFFF, 9'd300, $urandom);
    random_phase(200);
    set_regs(16'd0, 9'd1, 32'hFFFF_FFFF);
    random_phase(150);
    set_regs(16'($urandom), 9'd511, $urandom);
    random_phase(250);
    set_regs(16'($urandom), 9'($urandom_range(2, 40)), $urandom);
    random_phase(300);
    set_regs(16'($urandom), 9'($urandom_range(1, 8)), $urandom);
    random_phase(200);
    set_regs(DECAY_RESET, WINDOW_RESET, $urandom);
    idling = 0;
    random_phase(150);

    drain();
    repeat (130) @(posedge clk);
    $display("events accepted: %0d, volatility results checked: %0d", n_events, n_vols);
    $display("full windows blended: %0d, over six register settings", n_windows);
    if (errors == 0 && vol_expected.size() == 0) begin
      $display("tb_realized_volatility_tracker: done, clean");
    end else begin
      $display("tb_realized_volatility_tracker: done, errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_realized_volatility_tracker: done, errors");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/rvt_pkg.sv
rtl/rvt_in_if.sv
rtl/rvt_out_if.sv
rtl/rvt_datapath.sv
rtl/rvt_ctrl.sv
rtl/realized_volatility_tracker.sv
verif/tb_realized_volatility_tracker.sv
